/* hw/rtl/tvsg_pkg.sv */
// ============================================================================
// tvsg_pkg: shared types and constants for the three-voice sound generator
// Holds the input and result beat structs, the bus function codes, the
// envelope phase codes and the register map indexes.
// ============================================================================
`default_nettype none

package tvsg_pkg;

    // Bus function carried by each input beat.
    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_LINES = 2'd1,
        FUNC_WRITE = 2'd2,
        FUNC_READ  = 2'd3
    } t_func;

    // Envelope phase.
    typedef enum logic [1:0] {
        PHASE_SUS_LOW  = 2'd0,
        PHASE_SUS_HIGH = 2'd1,
        PHASE_ATTACK   = 2'd2,
        PHASE_RELEASE  = 2'd3
    } t_env_phase;

    // Register map.
    localparam logic [3:0] REG_TONE_A_FINE   = 4'd0;
    localparam logic [3:0] REG_TONE_A_COARSE = 4'd1;
    localparam logic [3:0] REG_TONE_B_FINE   = 4'd2;
    localparam logic [3:0] REG_TONE_B_COARSE = 4'd3;
    localparam logic [3:0] REG_TONE_C_FINE   = 4'd4;
    localparam logic [3:0] REG_TONE_C_COARSE = 4'd5;
    localparam logic [3:0] REG_NOISE_PERIOD  = 4'd6;
    localparam logic [3:0] REG_MIXER         = 4'd7;
    localparam logic [3:0] REG_AMP_A         = 4'd8;
    localparam logic [3:0] REG_AMP_B         = 4'd9;
    localparam logic [3:0] REG_AMP_C         = 4'd10;
    localparam logic [3:0] REG_ENV_LOW       = 4'd11;
    localparam logic [3:0] REG_ENV_HIGH      = 4'd12;
    localparam logic [3:0] REG_ENV_SHAPE     = 4'd13;
    localparam logic [3:0] REG_PORT_A        = 4'd14;

    localparam int unsigned NUM_REGS = 16;

    // Envelope shapes with special behavior at the end of a cycle.
    localparam logic [3:0] SHAPE_SAW_DOWN  = 4'h8;
    localparam logic [3:0] SHAPE_TRI_DOWN  = 4'hA;
    localparam logic [3:0] SHAPE_HOLD_B    = 4'hB;
    localparam logic [3:0] SHAPE_SAW_UP    = 4'hC;
    localparam logic [3:0] SHAPE_HOLD_D    = 4'hD;
    localparam logic [3:0] SHAPE_TRI_UP    = 4'hE;

    // One input beat.
    typedef struct packed {
        logic [1:0] func;
        logic       bus_dir;
        logic       bus_ctl;
        logic [7:0] data_in;
        logic [7:0] port_a_in;
    } t_in;

    // One result beat.
    typedef struct packed {
        logic [7:0] read_data;
        logic [3:0] amp_a;
        logic [3:0] amp_b;
        logic [3:0] amp_c;
    } t_out;

endpackage

`default_nettype wire

/* hw/rtl/three_voice_sound_generator.sv */
// Each result beat is registered in the output register, or held in the skid entry while the output stalls.
// Throughput: one input beat per cycle while the skid entry is empty; the state
// update and the mix of each beat fit in the single logic stage ahead of the two-entry result buffer.
// Reset: synchronous active low; clears the register file, the bus latches,
// all counters, the noise shifter and the envelope, and empties the buffer.
// ============================================================================
// three_voice_sound_generator: three-voice programmable sound generator
// Bus-style register interface, three tone counters, a noise shifter and a
// sixteen-step envelope, with a mixed amplitude returned for every beat.
// ============================================================================
`default_nettype none

module three_voice_sound_generator (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire tvsg_pkg::t_in i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output tvsg_pkg::t_out     o_out_data
);

    // Architectural state.
    logic [7:0]            r_regs [tvsg_pkg::NUM_REGS];
    logic [7:0]            r_sel;
    logic                  r_dir;
    logic                  r_ctl;
    logic [15:0]           r_tone_cnt [3];
    logic [2:0]            r_tone_lvl;
    logic [15:0]           r_noise_cnt;
    logic [15:0]           r_noise_shift;
    logic                  r_noise_lvl;
    logic [19:0]           r_env_cnt;
    logic [3:0]            r_env_step;
    tvsg_pkg::t_env_phase  r_env_phase;
    logic [3:0]            r_env_lvl;

    logic [7:0]            n_regs [tvsg_pkg::NUM_REGS];
    logic [7:0]            n_sel;
    logic                  n_dir;
    logic                  n_ctl;
    logic [15:0]           n_tone_cnt [3];
    logic [2:0]            n_tone_lvl;
    logic [15:0]           n_noise_cnt;
    logic [15:0]           n_noise_shift;
    logic                  n_noise_lvl;
    logic [19:0]           n_env_cnt;
    logic [3:0]            n_env_step;
    tvsg_pkg::t_env_phase  n_env_phase;
    logic [3:0]            n_env_lvl;

    // Result buffer: output register plus skid entry.
    logic                  r_out_valid;
    tvsg_pkg::t_out        r_out_data;
    logic                  r_skid_valid;
    tvsg_pkg::t_out        r_skid_data;

    tvsg_pkg::t_out        w_result;
    logic                  w_accept;
    logic                  w_take;

    // One tone tick: returns the toggled-or-held level over the new count.
    function automatic logic [16:0] f_tone(input logic [15:0] cnt, input logic [7:0] fine,
                                           input logic [3:0] coarse, input logic lvl);
        logic [16:0] inc;
        logic [16:0] thr;
        inc = {1'b0, cnt} + 17'd1;
        thr = {2'b00, coarse, fine, 3'b000};
        if (inc >= thr) begin
            return {~lvl, 16'd0};
        end
        return {lvl, inc[15:0]};
    endfunction

    // Mix one channel: gate by enabled tone and noise, then pick the amplitude.
    function automatic logic [3:0] f_mix(input logic tone_off, input logic noise_off,
                                         input logic tone_lvl, input logic noise_lvl,
                                         input logic [7:0] amp, input logic [3:0] env_lvl);
        logic on;
        on = (tone_off || tone_lvl) && (noise_off || noise_lvl);
        if (!on) begin
            return 4'd0;
        end
        if (amp[4]) begin
            return env_lvl;
        end
        return amp[3:0];
    endfunction

    assign w_accept   = i_in_valid && !r_skid_valid;
    assign w_take     = r_out_valid && !i_out_stall;
    assign o_in_stall = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Next state and result for the beat at the input.
    always_comb begin
        logic [16:0] tone_a;
        logic [16:0] tone_b;
        logic [16:0] tone_c;
        logic [16:0] noise_inc;
        logic [16:0] noise_thr;
        logic        noise_bit;
        logic [20:0] env_inc;
        logic [20:0] env_thr;
        logic [3:0]  env_step_inc;
        logic [7:0]  rd;

        n_regs        = r_regs;
        n_sel         = r_sel;
        n_dir         = r_dir;
        n_ctl         = r_ctl;
        n_tone_cnt    = r_tone_cnt;
        n_tone_lvl    = r_tone_lvl;
        n_noise_cnt   = r_noise_cnt;
        n_noise_shift = r_noise_shift;
        n_noise_lvl   = r_noise_lvl;
        n_env_cnt     = r_env_cnt;
        n_env_step    = r_env_step;
        n_env_phase   = r_env_phase;
        n_env_lvl     = r_env_lvl;
        rd            = 8'd0;

        tone_a = f_tone(r_tone_cnt[0], r_regs[tvsg_pkg::REG_TONE_A_FINE],
                        r_regs[tvsg_pkg::REG_TONE_A_COARSE][3:0], r_tone_lvl[0]);
        tone_b = f_tone(r_tone_cnt[1], r_regs[tvsg_pkg::REG_TONE_B_FINE],
                        r_regs[tvsg_pkg::REG_TONE_B_COARSE][3:0], r_tone_lvl[1]);
        tone_c = f_tone(r_tone_cnt[2], r_regs[tvsg_pkg::REG_TONE_C_FINE],
                        r_regs[tvsg_pkg::REG_TONE_C_COARSE][3:0], r_tone_lvl[2]);

        noise_inc = {1'b0, r_noise_cnt} + 17'd1;
        noise_thr = {9'd0, r_regs[tvsg_pkg::REG_NOISE_PERIOD][4:0], 3'b000};
        noise_bit = ~(r_noise_shift[15] ^ r_noise_shift[12]);

        env_inc      = {1'b0, r_env_cnt} + 21'd1;
        env_thr      = {1'b0, r_regs[tvsg_pkg::REG_ENV_HIGH],
                        r_regs[tvsg_pkg::REG_ENV_LOW], 4'b0000};
        env_step_inc = r_env_step + 4'd1;

        case (tvsg_pkg::t_func'(i_in_data.func))
            tvsg_pkg::FUNC_TICK: begin
                // Tone channels.
                n_tone_cnt[0] = tone_a[15:0];
                n_tone_cnt[1] = tone_b[15:0];
                n_tone_cnt[2] = tone_c[15:0];
                n_tone_lvl    = {tone_c[16], tone_b[16], tone_a[16]};

                // Noise shifter.
                if (noise_inc >= noise_thr) begin
                    n_noise_cnt   = 16'd0;
                    n_noise_shift = {r_noise_shift[14:0], noise_bit};
                    n_noise_lvl   = noise_bit;
                end else begin
                    n_noise_cnt = noise_inc[15:0];
                end

                // Envelope: step, follow the shape at the wrap, then set the level.
                if (env_inc < env_thr) begin
                    n_env_cnt = env_inc[19:0];
                end else begin
                    n_env_cnt  = 20'd0;
                    n_env_step = env_step_inc;
                    if (env_step_inc == 4'd0) begin
                        case (r_regs[tvsg_pkg::REG_ENV_SHAPE][3:0])
                            tvsg_pkg::SHAPE_SAW_DOWN,
                            tvsg_pkg::SHAPE_SAW_UP: begin
                                n_env_phase = r_env_phase;
                            end
                            tvsg_pkg::SHAPE_TRI_DOWN: begin
                                n_env_phase = tvsg_pkg::PHASE_ATTACK;
                                n_regs[tvsg_pkg::REG_ENV_SHAPE] = {4'd0, tvsg_pkg::SHAPE_TRI_UP};
                            end
                            tvsg_pkg::SHAPE_HOLD_B,
                            tvsg_pkg::SHAPE_HOLD_D: begin
                                n_env_phase = tvsg_pkg::PHASE_SUS_HIGH;
                            end
                            tvsg_pkg::SHAPE_TRI_UP: begin
                                n_env_phase = tvsg_pkg::PHASE_RELEASE;
                                n_regs[tvsg_pkg::REG_ENV_SHAPE] = {4'd0, tvsg_pkg::SHAPE_TRI_DOWN};
                            end
                            default: begin
                                n_env_phase = tvsg_pkg::PHASE_SUS_LOW;
                            end
                        endcase
                    end
                    case (n_env_phase)
                        tvsg_pkg::PHASE_SUS_HIGH: n_env_lvl = 4'hF;
                        tvsg_pkg::PHASE_ATTACK:   n_env_lvl = env_step_inc;
                        tvsg_pkg::PHASE_RELEASE:  n_env_lvl = 4'hF - env_step_inc;
                        default:                  n_env_lvl = 4'h0;
                    endcase
                end
            end
            tvsg_pkg::FUNC_LINES: begin
                n_dir = i_in_data.bus_dir;
                n_ctl = i_in_data.bus_ctl;
            end
            tvsg_pkg::FUNC_WRITE: begin
                // Address latch with BC1 high, register write with BC1 low.
                if (r_dir) begin
                    if (r_ctl) begin
                        n_sel = i_in_data.data_in;
                    end else if (r_sel[7:4] == 4'd0) begin
                        n_regs[r_sel[3:0]] = i_in_data.data_in;
                    end
                end
            end
            default: begin
                // Read: only with BDIR low and BC1 high, and inside the file.
                if (!r_dir && r_ctl && (r_sel[7:4] == 4'd0)) begin
                    if (r_sel[3:0] == tvsg_pkg::REG_PORT_A) begin
                        rd = i_in_data.port_a_in;
                    end else begin
                        rd = r_regs[r_sel[3:0]];
                    end
                end
            end
        endcase

        // Mix from the state left by this beat.
        w_result.read_data = rd;
        w_result.amp_a = f_mix(n_regs[tvsg_pkg::REG_MIXER][0], n_regs[tvsg_pkg::REG_MIXER][3],
                               n_tone_lvl[0], n_noise_lvl, n_regs[tvsg_pkg::REG_AMP_A],
                               n_env_lvl);
        w_result.amp_b = f_mix(n_regs[tvsg_pkg::REG_MIXER][1], n_regs[tvsg_pkg::REG_MIXER][4],
                               n_tone_lvl[1], n_noise_lvl, n_regs[tvsg_pkg::REG_AMP_B],
                               n_env_lvl);
        w_result.amp_c = f_mix(n_regs[tvsg_pkg::REG_MIXER][2], n_regs[tvsg_pkg::REG_MIXER][5],
                               n_tone_lvl[2], n_noise_lvl, n_regs[tvsg_pkg::REG_AMP_C],
                               n_env_lvl);
    end

    // State registers advance on every accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tvsg_pkg::NUM_REGS; i++) begin
                r_regs[i] <= 8'd0;
            end
            for (int i = 0; i < 3; i++) begin
                r_tone_cnt[i] <= 16'd0;
            end
            r_sel         <= 8'd0;
            r_dir         <= 1'b0;
            r_ctl         <= 1'b0;
            r_tone_lvl    <= 3'd0;
            r_noise_cnt   <= 16'd0;
            r_noise_shift <= 16'd0;
            r_noise_lvl   <= 1'b0;
            r_env_cnt     <= 20'd0;
            r_env_step    <= 4'd0;
            r_env_phase   <= tvsg_pkg::PHASE_SUS_LOW;
            r_env_lvl     <= 4'd0;
        end else if (w_accept) begin
            r_regs        <= n_regs;
            r_tone_cnt    <= n_tone_cnt;
            r_sel         <= n_sel;
            r_dir         <= n_dir;
            r_ctl         <= n_ctl;
            r_tone_lvl    <= n_tone_lvl;
            r_noise_cnt   <= n_noise_cnt;
            r_noise_shift <= n_noise_shift;
            r_noise_lvl   <= n_noise_lvl;
            r_env_cnt     <= n_env_cnt;
            r_env_step    <= n_env_step;
            r_env_phase   <= n_env_phase;
            r_env_lvl     <= n_env_lvl;
        end
    end

    // Result buffer: the skid entry catches a beat while the output is stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_data   <= r_skid_data;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else if (w_accept) begin
                r_out_data  <= w_result;
                r_out_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if (w_accept) begin
            r_skid_data  <= w_result;
            r_skid_valid <= 1'b1;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/tvsg_checker.sv */
// ============================================================================
// tvsg_port_checks: port-level checks for the three-voice sound generator
// Watches the handshakes of both channels and the result buffer behavior.
// ============================================================================
`default_nettype none

module tvsg_port_checks (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_in_valid,
    input wire logic            o_in_stall,
    input wire logic            o_out_valid,
    input wire logic            i_out_stall,
    input wire tvsg_pkg::t_out  o_out_data
);

    // A stalled result beat stays valid and keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result beat changed or dropped");

    // Reset leaves the result buffer empty and the input open.
    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("result buffer not empty after reset");

    // A beat accepted into an empty buffer shows up in the next cycle.
    a_accept_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !o_out_valid |=> o_out_valid)
        else $error("accepted beat did not reach the output");

    // The input only stalls while the output holds a beat.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with an empty output");

endmodule

bind three_voice_sound_generator tvsg_port_checks u_tvsg_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
